### hdl/crs_pkg.sv
`timescale 1ns / 1ps

package crs_pkg;

  // Default build of the stack
  localparam int STACK_DEPTH_DEF = 16;
  localparam int COORD_BITS_DEF  = 16;

  // Item opcodes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // Sequencer states
  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

endpackage

### hdl/crs_in_if.sv
`timescale 1ns / 1ps

// Input channel: one push or pop word per handshake
interface crs_in_if #(
  parameter int COORD_BITS = crs_pkg::COORD_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic                         opcode;
  logic signed [COORD_BITS-1:0] rect_x;
  logic signed [COORD_BITS-1:0] rect_y;
  logic        [COORD_BITS-2:0] rect_width;
  logic        [COORD_BITS-2:0] rect_height;

  modport source (
    output valid, opcode, rect_x, rect_y, rect_width, rect_height,
    input  ready
  );
  modport sink (
    input  valid, opcode, rect_x, rect_y, rect_width, rect_height,
    output ready
  );
endinterface

### hdl/crs_out_if.sv
`timescale 1ns / 1ps

// Result channel: current top rectangle and flags
interface crs_out_if #(
  parameter int COORD_BITS = crs_pkg::COORD_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] clip_x;
  logic signed [COORD_BITS-1:0] clip_y;
  logic        [COORD_BITS-2:0] clip_width;
  logic        [COORD_BITS-2:0] clip_height;
  logic                         clip_valid;
  logic                         push_dropped;

  modport source (
    output valid, clip_x, clip_y, clip_width, clip_height, clip_valid, push_dropped,
    input  ready
  );
  modport sink (
    input  valid, clip_x, clip_y, clip_width, clip_height, clip_valid, push_dropped,
    output ready
  );
endinterface

### hdl/crs_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM, one write and one registered read port
module crs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/crs_isect.sv
`timescale 1ns / 1ps

// Intersection of two rectangles; sizes clamp at zero
module crs_isect #(
  parameter int COORD_BITS = crs_pkg::COORD_BITS_DEF
) (
  input  logic signed [COORD_BITS-1:0] a_x,
  input  logic signed [COORD_BITS-1:0] a_y,
  input  logic        [COORD_BITS-2:0] a_w,
  input  logic        [COORD_BITS-2:0] a_h,
  input  logic signed [COORD_BITS-1:0] b_x,
  input  logic signed [COORD_BITS-1:0] b_y,
  input  logic        [COORD_BITS-2:0] b_w,
  input  logic        [COORD_BITS-2:0] b_h,
  output logic signed [COORD_BITS-1:0] r_x,
  output logic signed [COORD_BITS-1:0] r_y,
  output logic        [COORD_BITS-2:0] r_w,
  output logic        [COORD_BITS-2:0] r_h
);

  // far edges carried two bits wider so neither sum nor difference wraps
  localparam int EB = COORD_BITS + 2;
  localparam int SW = COORD_BITS - 1;

  logic signed [EB-1:0] ax_e, ay_e, bx_e, by_e;
  logic signed [EB-1:0] a_right, a_bottom, b_right, b_bottom;
  logic signed [EB-1:0] right, bottom, lx, ty, dw, dh;

  always_comb begin
    ax_e     = EB'(a_x);
    ay_e     = EB'(a_y);
    bx_e     = EB'(b_x);
    by_e     = EB'(b_y);
    a_right  = ax_e + signed'(EB'(a_w));
    a_bottom = ay_e + signed'(EB'(a_h));
    b_right  = bx_e + signed'(EB'(b_w));
    b_bottom = by_e + signed'(EB'(b_h));

    right  = (a_right < b_right) ? a_right : b_right;
    bottom = (a_bottom < b_bottom) ? a_bottom : b_bottom;
    lx     = (ax_e > bx_e) ? ax_e : bx_e;
    ty     = (ay_e > by_e) ? ay_e : by_e;
    dw     = right - lx;
    dh     = bottom - ty;

    r_x = lx[COORD_BITS-1:0];
    r_y = ty[COORD_BITS-1:0];
    // never above the pushed size, so the low bits hold it
    r_w = dw[EB-1] ? '0 : dw[SW-1:0];
    r_h = dh[EB-1] ? '0 : dh[SW-1:0];
  end

endmodule

### hdl/clip_rect_stack.sv
`timescale 1ns / 1ps

// Scissor rectangle stack.
// in_rect carries one word per item: a push (opcode 0) with a rectangle, or a
// pop (opcode 1). A push stores the rectangle intersected with the current
// top (or as is on an empty stack); a push onto a full stack is dropped and
// flagged. A pop on an empty stack changes nothing.
// out_clip returns one word per item: the top rectangle after the item,
// clip_valid when the stack is not empty, and push_dropped.
// Rectangles live in a RAM of STACK_DEPTH entries; the top is cached in a
// register so a push needs no read. A pop that uncovers an older entry goes
// through S_READ for the RAM read, during which in_rect.ready is low. A push,
// or a pop that leaves the stack empty, needs no S_READ: its result is loaded
// into the output register as the item is taken. A deeper pop's result goes
// from the RAM read register to the output register in S_READ.
// A new item is taken while the output register is empty or being drained
// in the same cycle; while the receiver stalls, in_rect.ready stays low.
// Reset empties the stack at once; no clearing pass over the RAM.
module clip_rect_stack #(
  parameter int STACK_DEPTH = crs_pkg::STACK_DEPTH_DEF,
  parameter int COORD_BITS  = crs_pkg::COORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  crs_in_if.sink      in_rect,
  crs_out_if.source   out_clip
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int LW = $clog2(STACK_DEPTH + 1);
  localparam int CB = COORD_BITS;
  localparam int SW = COORD_BITS - 1;
  localparam int EW = 2 * CB + 2 * SW;

  crs_pkg::state_t state_r, state_nxt;
  logic [LW-1:0]   level_r, level_nxt;
  logic [EW-1:0]   top_r;

  logic out_vld_r;
  logic signed [CB-1:0] out_x_r, out_y_r;
  logic [SW-1:0] out_w_r, out_h_r;
  logic out_cv_r, out_drop_r;

  logic in_acc, is_push, full, empty, deep;
  logic in_ready, pop_read, load_out;
  logic [EW-1:0] in_ent, isect_ent, new_ent, rd_ent;
  logic signed [CB-1:0] ix, iy;
  logic [SW-1:0] iw, ih;

  assign in_acc  = in_rect.valid && in_ready;
  assign is_push = (in_rect.opcode == crs_pkg::OP_PUSH);
  assign full    = (level_r == LW'(STACK_DEPTH));
  assign empty   = (level_r == '0);
  assign deep    = (level_r > LW'(1));

  // Intersection with the cached top
  crs_isect #(.COORD_BITS(CB)) u_isect (
    .a_x (in_rect.rect_x),
    .a_y (in_rect.rect_y),
    .a_w (in_rect.rect_width),
    .a_h (in_rect.rect_height),
    .b_x (top_r[EW-1 -: CB]),
    .b_y (top_r[EW-1-CB -: CB]),
    .b_w (top_r[2*SW-1 -: SW]),
    .b_h (top_r[SW-1:0]),
    .r_x (ix),
    .r_y (iy),
    .r_w (iw),
    .r_h (ih)
  );

  assign in_ent    = {in_rect.rect_x, in_rect.rect_y, in_rect.rect_width, in_rect.rect_height};
  assign isect_ent = {ix, iy, iw, ih};
  assign new_ent   = empty ? in_ent : isect_ent;

  // Rectangle store; entry level-1 is the top
  crs_ram #(.WIDTH(EW), .DEPTH(STACK_DEPTH)) u_ram (
    .clk   (clk),
    .we    (in_acc && is_push && !full),
    .waddr (level_r[AW-1:0]),
    .wdata (new_ent),
    .re    (pop_read),
    .raddr (AW'(level_r - LW'(2))),
    .rdata (rd_ent)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      crs_pkg::S_IDLE: begin
        if (in_acc && !is_push && deep) begin
          state_nxt = crs_pkg::S_READ;
        end
      end
      crs_pkg::S_READ: state_nxt = crs_pkg::S_IDLE;
      default:         state_nxt = crs_pkg::S_IDLE;
    endcase
  end

  // Sequencer outputs; the read wait doubles as the RAM interlock
  always_comb begin
    in_ready = 1'b0;
    pop_read = 1'b0;
    load_out = 1'b0;
    case (state_r)
      crs_pkg::S_IDLE: begin
        in_ready = !out_vld_r || out_clip.ready;
        pop_read = in_acc && !is_push && deep;
        load_out = in_acc && (is_push || !deep);
      end
      crs_pkg::S_READ: load_out = 1'b1;
      default: ;
    endcase
  end

  // Stack level
  always_comb begin
    level_nxt = level_r;
    if (in_acc) begin
      if (is_push && !full) begin
        level_nxt = level_r + LW'(1);
      end else if (!is_push && !empty) begin
        level_nxt = level_r - LW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= crs_pkg::S_IDLE;
      level_r <= '0;
    end else begin
      state_r <= state_nxt;
      level_r <= level_nxt;
    end
  end

  // Cached top
  always_ff @(posedge clk) begin
    if (in_acc && is_push && !full) begin
      top_r <= new_ent;
    end else if (state_r == crs_pkg::S_READ) begin
      top_r <= rd_ent;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (load_out) begin
      out_vld_r <= 1'b1;
    end else if (out_clip.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      if (state_r == crs_pkg::S_READ) begin
        {out_x_r, out_y_r, out_w_r, out_h_r} <= rd_ent;
        out_cv_r   <= 1'b1;
        out_drop_r <= 1'b0;
      end else if (is_push && full) begin
        {out_x_r, out_y_r, out_w_r, out_h_r} <= top_r;
        out_cv_r   <= 1'b1;
        out_drop_r <= 1'b1;
      end else if (is_push) begin
        {out_x_r, out_y_r, out_w_r, out_h_r} <= new_ent;
        out_cv_r   <= 1'b1;
        out_drop_r <= 1'b0;
      end else begin
        // pop leaving the stack empty
        {out_x_r, out_y_r, out_w_r, out_h_r} <= '0;
        out_cv_r   <= 1'b0;
        out_drop_r <= 1'b0;
      end
    end
  end

  assign in_rect.ready         = in_ready;
  assign out_clip.valid        = out_vld_r;
  assign out_clip.clip_x       = out_x_r;
  assign out_clip.clip_y       = out_y_r;
  assign out_clip.clip_width   = out_w_r;
  assign out_clip.clip_height  = out_h_r;
  assign out_clip.clip_valid   = out_cv_r;
  assign out_clip.push_dropped = out_drop_r;

  // Checks
  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= LW'(STACK_DEPTH))
    else $error("stack level above depth");

  a_pop_read: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !is_push && deep) |=> (state_r == crs_pkg::S_READ) && !out_vld_r)
    else $error("pop of a deep stack did not wait for the RAM read");

  a_drop_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && is_push && full) |=> out_vld_r && out_drop_r && out_cv_r)
    else $error("push onto full stack not flagged");

  a_cv_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_cv_r == (level_r != '0)))
    else $error("clip_valid disagrees with stack level");

endmodule
